@@ rtl/task_wait_queue_links_defines.svh @@
// Assertion macros used by the task queue checker.
`ifndef TASK_WAIT_QUEUE_LINKS_DEFINES_SVH
`define TASK_WAIT_QUEUE_LINKS_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define TWQL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("task queue check failed");

// Consequent checked in the same cycle as the antecedent.
`define TWQL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("task queue check failed");

`endif

@@ rtl/twql_pkg.sv @@
// Types and constants for the task wait queue block.
`default_nettype none

package twql_pkg;

    localparam int DEF_NUM_TASKS = 16;
    localparam int NUM_QUEUES    = 8;
    localparam int QSEL_W        = 3;
    localparam int OPC_W         = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_RM_HEAD = 2'd1,
        OP_RM_TASK = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_APP1,
        S_APP2,
        S_RMH1,
        S_RMT1,
        S_TRD,
        S_TDA
    } t_state;

endpackage

`default_nettype wire

@@ rtl/task_wait_queue_links.sv @@
// Task wait queues as doubly linked lists: one operation per beat, one result beat.
// Per beat the sequencer decodes (S_DEC), updates links (S_APP1 then S_APP2 to append to
// a non-empty queue, S_RMH1 or S_RMT1 to remove), reads head and tail (S_TRD, S_TDA) and
// loads the result beat; no new beat is taken before then, as each link memory has one
// registered read port, which the sequencer visits once per dependent link access.
// Reset (synchronous, active low) empties every queue; link memories are not cleared.
`default_nettype none

module task_wait_queue_links
    import twql_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    localparam int TASK_W = $clog2(NUM_TASKS),
    localparam int NIL_W  = $clog2(NUM_TASKS + 1),
    localparam int IN_W   = OPC_W + QSEL_W + TASK_W,
    localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_DW = ((3 * NIL_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_DW-1:0]  i_s_tdata,   // opcode, queue_sel, task_id
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_DW-1:0]      o_m_tdata    // head_task, tail_task, removed_task
);

    localparam logic [NIL_W-1:0] NIL = NIL_W'(NUM_TASKS);
    localparam int Q_LO = OPC_W;
    localparam int T_LO = OPC_W + QSEL_W;

    t_state                 r_state, n_state;
    t_opcode                r_op;
    logic [QSEL_W-1:0]      r_q;
    logic [TASK_W-1:0]      r_t;
    logic [NIL_W-1:0]       r_h;
    logic [NIL_W-1:0]       r_rem, n_rem;
    logic [NIL_W-1:0]       r_head [NUM_QUEUES];

    logic [NIL_W-1:0]       r_fwd_mem [NUM_TASKS];
    logic [TASK_W-1:0]      r_bwd_mem [NUM_TASKS];
    logic [NIL_W-1:0]       r_fwd_rd;
    logic [TASK_W-1:0]      r_bwd_rd;

    logic                   fwd_we, bwd_we, head_we;
    logic [TASK_W-1:0]      fwd_wa, bwd_wa, rd_addr;
    logic [NIL_W-1:0]       fwd_wd, head_wd;
    logic [TASK_W-1:0]      bwd_wd;
    logic                   load_out;

    logic                   accept;
    logic                   t_ok, h_ok;
    logic [NIL_W-1:0]       head_cur, head_out, tail_out;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign accept     = i_s_tvalid && o_s_tready;

    assign t_ok     = {1'b0, r_t} < NIL;
    assign h_ok     = r_h < NIL;
    assign head_cur = r_head[r_q];
    assign head_out = (head_cur < NIL) ? head_cur : NIL;
    assign tail_out = ((head_cur < NIL) && ({1'b0, r_bwd_rd} < NIL)) ? {1'b0, r_bwd_rd} : NIL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // captured operation and bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= t_opcode'(i_s_tdata[OPC_W-1:0]);
            r_q  <= i_s_tdata[Q_LO +: QSEL_W];
            r_t  <= i_s_tdata[T_LO +: TASK_W];
            r_h  <= r_head[i_s_tdata[Q_LO +: QSEL_W]];
        end
        r_rem <= n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= NIL;
            end
        end else if (head_we) begin
            r_head[r_q] <= head_wd;
        end
    end

    // link memories: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (fwd_we && ({1'b0, fwd_wa} < NIL)) begin
            r_fwd_mem[fwd_wa] <= fwd_wd;
        end
        r_fwd_rd <= r_fwd_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bwd_we && ({1'b0, bwd_wa} < NIL)) begin
            r_bwd_mem[bwd_wa] <= bwd_wd;
        end
        r_bwd_rd <= r_bwd_mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        fwd_we   = 1'b0;
        fwd_wa   = r_t;
        fwd_wd   = NIL;
        bwd_we   = 1'b0;
        bwd_wa   = r_t;
        bwd_wd   = r_t;
        head_we  = 1'b0;
        head_wd  = NIL;
        rd_addr  = r_h[TASK_W-1:0];
        load_out = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_rem   = NIL;
                n_state = S_TRD;
                unique case (r_op)
                    OP_APPEND: begin
                        if (t_ok && !h_ok) begin
                            // empty queue: the task is head and tail
                            head_we = 1'b1;
                            head_wd = {1'b0, r_t};
                            fwd_we  = 1'b1;
                            bwd_we  = 1'b1;
                        end else if (t_ok) begin
                            n_state = S_APP1;
                        end
                    end
                    OP_RM_HEAD: begin
                        if (h_ok) begin
                            n_rem   = r_h;
                            n_state = S_RMH1;
                        end
                    end
                    OP_RM_TASK: begin
                        if (t_ok && h_ok && (r_h == {1'b0, r_t})) begin
                            n_rem   = r_h;
                            n_state = S_RMH1;
                        end else if (t_ok && h_ok) begin
                            n_rem   = {1'b0, r_t};
                            rd_addr = r_t;
                            n_state = S_RMT1;
                        end
                    end
                    OP_NOP: begin
                    end
                endcase
            end
            S_APP1: begin
                // old tail arrives from the head's backward link
                fwd_we  = 1'b1;
                fwd_wa  = r_bwd_rd;
                fwd_wd  = {1'b0, r_t};
                bwd_we  = 1'b1;
                bwd_wa  = r_t;
                bwd_wd  = r_bwd_rd;
                n_state = S_APP2;
            end
            S_APP2: begin
                fwd_we  = 1'b1;
                fwd_wa  = r_t;
                fwd_wd  = NIL;
                bwd_we  = 1'b1;
                bwd_wa  = r_h[TASK_W-1:0];
                bwd_wd  = r_t;
                n_state = S_TRD;
            end
            S_RMH1: begin
                // new head inherits the tail pointer
                head_we = 1'b1;
                head_wd = (r_fwd_rd < NIL) ? r_fwd_rd : NIL;
                bwd_we  = r_fwd_rd < NIL;
                bwd_wa  = r_fwd_rd[TASK_W-1:0];
                bwd_wd  = r_bwd_rd;
                n_state = S_TRD;
            end
            S_RMT1: begin
                fwd_we  = 1'b1;
                fwd_wa  = r_bwd_rd;
                fwd_wd  = r_fwd_rd;
                bwd_we  = 1'b1;
                bwd_wa  = (r_fwd_rd < NIL) ? r_fwd_rd[TASK_W-1:0] : r_h[TASK_W-1:0];
                bwd_wd  = r_bwd_rd;
                n_state = S_TRD;
            end
            S_TRD: begin
                rd_addr = head_cur[TASK_W-1:0];
                n_state = S_TDA;
            end
            S_TDA: begin
                rd_addr = head_cur[TASK_W-1:0];
                if (!o_m_tvalid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (load_out) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_m_tdata <= OUT_DW'({r_rem, tail_out, head_out});
        end
    end

endmodule

`default_nettype wire

@@ rtl/twql_checker.sv @@
// Port-level checks for the task wait queue block, bound to its top level.
`default_nettype none
`include "task_wait_queue_links_defines.svh"

module twql_checker
    import twql_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    localparam int TASK_W = $clog2(NUM_TASKS),
    localparam int NIL_W  = $clog2(NUM_TASKS + 1),
    localparam int IN_W   = OPC_W + QSEL_W + TASK_W,
    localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_DW = ((3 * NIL_W + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic [IN_DW-1:0]  i_s_tdata,   // opcode, queue_sel, task_id
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [OUT_DW-1:0] o_m_tdata    // head_task, tail_task, removed_task
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_s_tvalid && o_s_tready && (i_s_tdata == i_s_tdata);
    assign out_stall = o_m_tvalid && !i_m_tready;

    `TWQL_ASSERT_NEXT(a_out_held, out_stall, o_m_tvalid)
    `TWQL_ASSERT_NEXT(a_busy_after_beat, in_beat, !o_s_tready)
    `TWQL_ASSERT_NOW(a_min_latency, $rose(o_m_tvalid), !$past(in_beat, 1) && !$past(in_beat, 2))
    `TWQL_ASSERT_NEXT(a_out_stable, out_stall, $stable(o_m_tdata))

endmodule

bind task_wait_queue_links twql_checker #(.NUM_TASKS(NUM_TASKS)) u_twql_checker (.*);

`default_nettype wire
